// File: src/pge_pkg.sv
package pge_pkg;

    localparam int WORD_BITS   = 32;
    localparam int CODE_BITS   = 64;
    localparam int QFIELD_BITS = 16;
    localparam int LEN_W       = 6;
    localparam int ADDR_BITS   = 5;

    localparam logic [3:0]  LEN_ESCAPE = 4'd15;
    localparam logic [30:0] ESCAPE_GAP = 31'h0000_8000;
    localparam int          TOP_BIT_LIMIT = 30;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_COMP_TYPE  = 3'd0;
    localparam logic [2:0] REG_MAX_WORD   = 3'd1;
    localparam logic [2:0] REG_MIN_WORD   = 3'd2;
    localparam logic [2:0] REG_MIN_FIXED  = 3'd3;
    localparam logic [2:0] REG_SCALE      = 3'd4;

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_GAP,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        logic        comp_type;
        logic [31:0] max_weight_word;
        logic [31:0] min_weight_word;
        logic [31:0] min_weight_fixed;
        logic [31:0] weight_scale;
    } cfg_t;

    // One coded item, its new bits left-aligned in bits.
    typedef struct packed {
        kind_t                  kind;
        logic                   last;
        logic [WORD_BITS-1:0]   hdr;
        logic [LEN_W-1:0]       len;
        logic [CODE_BITS-1:0]   bits;
    } code_t;

endpackage

// File: src/posting_list_gap_encoder_unit.sv
// Channel     | Direction | Transfer carries
// ------------+-----------+---------------------------------------------------
// s_axis      | in        | tdata: doc_id[30:0], weight[62:31]; tlast: last_item
// m_axis      | out       | tdata: out_word; tlast: end_of_list; tuser: error
// APB         | in/out    | comp_type, max/min weight words, min weight, scale
//
// Three register stages (offset, product and list control, code build) feed an
// output group register, from which the first word of an item is presented.
// An item that completes words holds the group until its last word leaves, and
// one that completes none is taken without loading it, so the packer sets the rate.
// Reset clears the pipeline, pending word and list state; a stall on either
// side backs up through the stage valid bits and nothing is lost.
module posting_list_gap_encoder_unit
    import pge_pkg::*;
#(
    parameter int WEIGHT_BITS = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // doc_id[30:0], weight[62:31], zero
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // out_word[31:0]
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser,  // error[0]
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    cfg_t        cfg;
    logic        code_valid;
    logic        code_ready;
    code_t       code;

    logic [4:0]  used_reg;
    logic [4:0]  used_next;
    logic [31:0] pend_reg;
    logic [31:0] pend_next;

    logic [31:0] grp_word_reg [0:3];
    logic [31:0] ld_word      [0:3];
    logic [2:0]  grp_rem_reg;
    logic [2:0]  grp_rem_next;
    logic [1:0]  grp_idx_reg;
    logic [1:0]  grp_idx_next;
    logic        grp_eol_reg;
    logic        grp_err_reg;
    logic [2:0]  ld_cnt;
    logic        ld_eol;
    logic        ld_err;
    logic        load;

    logic        take;
    logic        m_xfer;
    logic [4:0]  base_used;
    logic [31:0] base_pend;
    logic [127:0] acc;
    logic [6:0]  total;
    logic [1:0]  nw;
    logic [4:0]  rem;
    logic        pad;
    logic [31:0] pad_mask;
    logic [31:0] wd [0:2];
    logic [31:0] tail_word;

    pge_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pge_coder #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_coder (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_doc     (s_axis_tdata[30:0]),
        .in_weight  (s_axis_tdata[62:31]),
        .in_last    (s_axis_tlast),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code       (code)
    );

    // The next code is taken at the edge where the last word of the group leaves.
    assign code_ready = (grp_rem_reg == 3'd0) || ((grp_rem_reg == 3'd1) && m_axis_tready);
    assign take       = code_valid && code_ready;
    assign m_xfer     = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = (grp_rem_reg != 3'd0);
    assign m_axis_tdata  = grp_word_reg[grp_idx_reg];
    assign m_axis_tlast  = grp_eol_reg && (grp_rem_reg == 3'd1);
    assign m_axis_tuser  = grp_err_reg;

    // The new bits are placed straight after the bits already pending.
    assign base_used = (code.kind == KIND_FIRST) ? 5'd0 : used_reg;
    assign base_pend = (code.kind == KIND_FIRST) ? 32'd0 : pend_reg;
    assign acc       = {base_pend, 96'd0} | ({code.bits, 64'd0} >> base_used);
    assign total     = 7'(base_used) + 7'(code.len);
    assign nw        = total[6:5];
    assign rem       = total[4:0];
    assign pad       = code.last && (rem != 5'd0);
    assign pad_mask  = 32'hFFFF_FFFF >> rem;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wd[i] = acc[127 - 32*i -: 32];
            if (pad && (nw == 2'(i)))
            begin
                wd[i] = wd[i] | pad_mask;
            end
        end
    end

    always_comb
    begin
        unique case (nw)
            2'd0:    tail_word = acc[127:96];
            2'd1:    tail_word = acc[95:64];
            default: tail_word = acc[63:32];
        endcase
    end

    always_comb
    begin
        ld_word[0] = wd[0];
        ld_word[1] = wd[1];
        ld_word[2] = wd[2];
        ld_word[3] = wd[2];
        ld_cnt     = 3'(nw) + 3'(pad);
        ld_eol     = code.last;
        ld_err     = 1'b0;
        unique case (code.kind)
            KIND_FIRST:
            begin
                ld_word[0] = code.hdr;
                ld_word[1] = cfg.max_weight_word;
                ld_word[2] = cfg.min_weight_word;
                ld_word[3] = wd[0];
                ld_cnt     = 3'd3 + 3'(pad);
            end
            KIND_ERROR:
            begin
                ld_word[0] = 32'd0;
                ld_cnt     = 3'd1;
                ld_eol     = 1'b1;
                ld_err     = 1'b1;
            end
            default:
            begin
                ld_cnt = 3'(nw) + 3'(pad);
            end
        endcase
    end

    assign load = take && (ld_cnt != 3'd0);

    always_comb
    begin
        used_next    = used_reg;
        pend_next    = pend_reg;
        grp_rem_next = grp_rem_reg;
        grp_idx_next = grp_idx_reg;
        if (take)
        begin
            if ((code.kind == KIND_ERROR) || code.last)
            begin
                used_next = 5'd0;
                pend_next = 32'd0;
            end
            else
            begin
                used_next = rem;
                pend_next = tail_word;
            end
        end
        if (load)
        begin
            grp_rem_next = ld_cnt;
            grp_idx_next = 2'd0;
        end
        else if (m_xfer)
        begin
            grp_rem_next = grp_rem_reg - 3'd1;
            grp_idx_next = grp_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 5'd0;
            pend_reg    <= 32'd0;
            grp_rem_reg <= 3'd0;
            grp_idx_reg <= 2'd0;
        end
        else
        begin
            used_reg    <= used_next;
            pend_reg    <= pend_next;
            grp_rem_reg <= grp_rem_next;
            grp_idx_reg <= grp_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                grp_word_reg[i] <= ld_word[i];
            end
            grp_eol_reg <= ld_eol;
            grp_err_reg <= ld_err;
        end
    end

    a_error_ends_list: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 32'd0))
        else $error("error transfer without end of list or with a non-zero word");

    a_last_empties_pending: assert property (@(posedge clk) disable iff (!rst_n)
        take && code.last |=> (used_reg == 5'd0) && (pend_reg == 32'd0))
        else $error("pending word not cleared after the last item");

    a_group_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ({2'd0, grp_idx_reg} + {1'b0, grp_rem_reg}) <= 4'd4)
        else $error("output group index runs past its four words");

endmodule

// File: src/pge_cfg.sv
module pge_cfg
    import pge_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_COMP_TYPE: cfg_next.comp_type        = pwdata[0];
                REG_MAX_WORD:  cfg_next.max_weight_word  = pwdata;
                REG_MIN_WORD:  cfg_next.min_weight_word  = pwdata;
                REG_MIN_FIXED: cfg_next.min_weight_fixed = pwdata;
                REG_SCALE:     cfg_next.weight_scale     = pwdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COMP_TYPE: prdata = {31'd0, cfg_reg.comp_type};
            REG_MAX_WORD:  prdata = cfg_reg.max_weight_word;
            REG_MIN_WORD:  prdata = cfg_reg.min_weight_word;
            REG_MIN_FIXED: prdata = cfg_reg.min_weight_fixed;
            REG_SCALE:     prdata = cfg_reg.weight_scale;
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/pge_coder.sv
module pge_coder
    import pge_pkg::*;
#(
    parameter int WEIGHT_BITS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [30:0] in_doc,
    input  logic [31:0] in_weight,
    input  logic        in_last,
    output logic        code_valid,
    input  logic        code_ready,
    output code_t       code
);

    localparam logic [31:0] QMAX = 32'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam int          QPAD = QFIELD_BITS - WEIGHT_BITS;

    // Stage 1: input register with weight offset
    logic        v1_reg;
    logic        v1_next;
    logic [30:0] doc1_reg;
    logic        last1_reg;
    logic [31:0] wd1_reg;
    logic        below1_reg;
    logic [32:0] wdiff;

    // Stage 2: list control, gap and product
    logic        v2_reg;
    logic        v2_next;
    kind_t       kind2_reg;
    kind_t       kind2;
    logic        keep2;
    logic        last2_reg;
    logic [30:0] doc2_reg;
    logic [30:0] d2_reg;
    logic [4:0]  k2_reg;
    logic [31:0] prod_hi2_reg;
    logic        below2_reg;
    logic [30:0] prev_doc_reg;
    logic [30:0] prev_doc_next;
    logic        in_list_reg;
    logic        in_list_next;
    logic        discard_reg;
    logic        discard_next;
    logic [30:0] gap;
    logic [4:0]  top_k;
    logic [63:0] prod;

    // Stage 3: code word
    logic        v3_reg;
    logic        v3_next;
    code_t       code_reg;
    code_t       code3;
    logic [WEIGHT_BITS-1:0] q;
    logic [QFIELD_BITS-1:0] q_al;
    logic        esc;
    logic [4:0]  k_esc;
    logic [3:0]  len_bits;
    logic [7:0]  len_al;
    logic [4:0]  dsh;
    logic [30:0] dl_al;

    logic        ready1;
    logic        ready2;
    logic        ready3;
    logic        adv12;
    logic        adv23;
    logic        acc1;

    assign ready3   = !v3_reg || code_ready;
    assign adv23    = v2_reg && ready3;
    assign ready2   = !v2_reg || ready3;
    assign adv12    = v1_reg && ready2;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;
    assign acc1     = in_valid && ready1;

    assign code_valid = v3_reg;
    assign code       = code_reg;

    assign wdiff = {1'b0, in_weight} - {1'b0, cfg.min_weight_fixed};

    // ---------------- stage 2 logic
    assign gap  = doc1_reg - prev_doc_reg;
    assign prod = 64'(wd1_reg) * 64'(cfg.weight_scale);

    always_comb
    begin
        top_k = 5'd0;
        for (int i = 1; i <= TOP_BIT_LIMIT; i++)
        begin
            if (gap[i])
            begin
                top_k = 5'(i);
            end
        end
    end

    always_comb
    begin
        prev_doc_next = prev_doc_reg;
        in_list_next  = in_list_reg;
        discard_next  = discard_reg;
        kind2         = KIND_GAP;
        keep2         = 1'b0;
        if (adv12)
        begin
            priority if (discard_reg)
            begin
                // Items after a failed id are dropped up to the end of the list.
                if (last1_reg)
                begin
                    discard_next = 1'b0;
                end
            end
            else if (!in_list_reg)
            begin
                kind2         = KIND_FIRST;
                keep2         = 1'b1;
                prev_doc_next = doc1_reg;
                in_list_next  = !last1_reg;
            end
            else if (doc1_reg <= prev_doc_reg)
            begin
                kind2        = KIND_ERROR;
                keep2        = 1'b1;
                in_list_next = 1'b0;
                discard_next = !last1_reg;
            end
            else
            begin
                kind2         = KIND_GAP;
                keep2         = 1'b1;
                prev_doc_next = doc1_reg;
                in_list_next  = !last1_reg;
            end
        end
    end

    // ---------------- stage 3 logic
    always_comb
    begin
        if (below2_reg)
        begin
            q = '0;
        end
        else if (prod_hi2_reg > QMAX)
        begin
            q = QMAX[WEIGHT_BITS-1:0];
        end
        else
        begin
            q = prod_hi2_reg[WEIGHT_BITS-1:0];
        end
    end

    assign q_al  = QFIELD_BITS'(q) << QPAD;
    assign esc   = (cfg.comp_type == 1'b0) && (d2_reg >= ESCAPE_GAP);
    assign k_esc = k2_reg - 5'(LEN_ESCAPE);
    // Shifting the gap up by (31 - k) drops its top bit and left-aligns the rest.
    assign dsh   = 5'd31 - k2_reg;
    assign dl_al = d2_reg << dsh;

    always_comb
    begin
        priority if (cfg.comp_type)
        begin
            len_bits = 4'd5;
            len_al   = {k2_reg, 3'd0};
        end
        else if (esc)
        begin
            len_bits = 4'd8;
            len_al   = {LEN_ESCAPE, k_esc[3:0]};
        end
        else
        begin
            len_bits = 4'd4;
            len_al   = {k2_reg[3:0], 4'd0};
        end
    end

    always_comb
    begin
        code3.kind = kind2_reg;
        code3.last = last2_reg;
        code3.hdr  = 32'd0 - {1'b0, doc2_reg};
        if (kind2_reg == KIND_FIRST)
        begin
            code3.len  = LEN_W'(WEIGHT_BITS + 2);
            code3.bits = {q_al, 48'd0}
                       | ({1'b0, cfg.comp_type, 62'd0} >> WEIGHT_BITS);
        end
        else
        begin
            code3.len  = LEN_W'(len_bits) + LEN_W'(k2_reg) + LEN_W'(WEIGHT_BITS);
            code3.bits = {len_al, 56'd0}
                       | ({dl_al, 33'd0} >> len_bits)
                       | ({q_al, 48'd0} >> (LEN_W'(len_bits) + LEN_W'(k2_reg)));
        end
    end

    // ---------------- control registers
    always_comb
    begin
        v1_next = acc1 ? 1'b1 : (adv12 ? 1'b0 : v1_reg);
        v2_next = adv12 ? keep2 : (adv23 ? 1'b0 : v2_reg);
        v3_next = adv23 ? 1'b1 : ((v3_reg && code_ready) ? 1'b0 : v3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            prev_doc_reg <= '0;
            in_list_reg  <= 1'b0;
            discard_reg  <= 1'b0;
        end
        else
        begin
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            v3_reg       <= v3_next;
            prev_doc_reg <= prev_doc_next;
            in_list_reg  <= in_list_next;
            discard_reg  <= discard_next;
        end
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        if (acc1)
        begin
            doc1_reg   <= in_doc;
            last1_reg  <= in_last;
            wd1_reg    <= wdiff[31:0];
            below1_reg <= wdiff[32];
        end
        if (adv12)
        begin
            kind2_reg    <= kind2;
            last2_reg    <= last1_reg;
            doc2_reg     <= doc1_reg;
            d2_reg       <= gap;
            k2_reg       <= top_k;
            prod_hi2_reg <= prod[63:32];
            below2_reg   <= below1_reg;
        end
        if (adv23)
        begin
            code_reg <= code3;
        end
    end

    a_discard_outside_list: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> !in_list_reg)
        else $error("discarding while a list is open");

endmodule
